### hw/rtl/rgbdb_pkg.sv
// ----------------------------------------------------------------------------
// rgbdb_pkg
// shared types, codes and constants of the rgb565 decimate/binarize block
// ----------------------------------------------------------------------------
`default_nettype none

package rgbdb_pkg;

  // frame size limits, in raw pixels
  localparam int MAX_COLUMNS = 1024;
  localparam int MAX_ROWS    = 1024;

  // field widths
  localparam int PIXEL_W     = 16;
  localparam int POS_W       = 10;
  localparam int PHASE_W     = 4;
  localparam int THRESHOLD_W = 6;
  localparam int STEP_W      = 4;
  localparam int CFG_DATA_W  = 6;
  localparam int CFG_INDEX_W = 1;
  localparam int RAW_W       = POS_W + STEP_W;
  localparam int GRAY_SUM_W  = 13;
  localparam int GRAY_SHIFT  = 7;
  localparam int GRAY_W      = GRAY_SUM_W - GRAY_SHIFT;

  // luma weights, sum shifted right by GRAY_SHIFT
  localparam logic [GRAY_SUM_W-1:0] WEIGHT_R = GRAY_SUM_W'(38);
  localparam logic [GRAY_SUM_W-1:0] WEIGHT_G = GRAY_SUM_W'(75);
  localparam logic [GRAY_SUM_W-1:0] WEIGHT_B = GRAY_SUM_W'(15);

  // reset values of the registers
  localparam logic [THRESHOLD_W-1:0] THRESHOLD_RESET = THRESHOLD_W'(35);
  localparam logic [STEP_W-1:0]      STEP_RESET      = STEP_W'(5);

  // position saturation and parked phase
  localparam logic [POS_W-1:0]   POS_MAX    = {POS_W{1'b1}};
  localparam logic [PHASE_W-1:0] PHASE_PARK = {PHASE_W{1'b1}};

  // result queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  // register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_GRAY_THRESHOLD  = 1'b0,
    REG_DECIMATION_STEP = 1'b1
  } reg_index_t;

  // result kinds
  typedef enum logic {
    KIND_POINT = 1'b0,
    KIND_FRAME = 1'b1
  } kind_t;

  typedef struct packed {
    logic             kind;
    logic [POS_W-1:0] point_x;
    logic [POS_W-1:0] point_y;
    logic             last;
  } result_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [POS_W-1:0]   pos;
  } counter_t;

endpackage

`default_nettype wire

### hw/rtl/rgb565_decimate_binarize_top.sv
// ----------------------------------------------------------------------------
// rgb565_decimate_binarize_top
// decimates an rgb565 pixel stream, thresholds the gray level of kept pixels
// and emits marked points plus a frame-done result per frame
// ----------------------------------------------------------------------------
// channel   direction  handshake                   payload
// pixel     in         pixel_valid / pixel_stall   pixel, row_end, frame_end
// result    out        result_valid / result_stall kind, point_x, point_y, last
// config    in         cfg_write                   cfg_index, cfg_data
//
// one pixel transfer per cycle while pixel_stall is low; a pixel is held in
// the input register feeding gray/threshold logic, then enters the queue
// every pixel waits in the input register until two queue slots are free,
// room for a marked pixel that also ends a frame and pushes two results
// the 4-entry result queue takes new pixels while results wait on a stall
// rst is synchronous, active high; it empties the queue and clears counters
// ----------------------------------------------------------------------------
`default_nettype none

module rgb565_decimate_binarize_top (
  input  wire                                  clk,
  input  wire                                  rst,
  // configuration
  input  wire                                  cfg_write,
  input  wire  [rgbdb_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire  [rgbdb_pkg::CFG_DATA_W-1:0]     cfg_data,
  // pixel stream
  input  wire                                  pixel_valid,
  output logic                                 pixel_stall,
  input  wire  [rgbdb_pkg::PIXEL_W-1:0]        pixel,
  input  wire                                  row_end,
  input  wire                                  frame_end,
  // results
  output logic                                 result_valid,
  input  wire                                  result_stall,
  output logic                                 kind,
  output logic [rgbdb_pkg::POS_W-1:0]          point_x,
  output logic [rgbdb_pkg::POS_W-1:0]          point_y,
  output logic                                 last
);

  import rgbdb_pkg::*;

  // configuration registers
  logic [THRESHOLD_W-1:0] gray_threshold;
  logic [STEP_W-1:0]      decimation_step;

  // input register
  logic               s1_valid;
  logic [PIXEL_W-1:0] s1_pixel;
  logic               s1_row_end;
  logic               s1_frame_end;

  // decimation counters
  logic [PHASE_W-1:0] column_phase;
  logic [POS_W-1:0]   decimated_x;
  logic [PHASE_W-1:0] row_phase;
  logic [POS_W-1:0]   decimated_y;

  // result queue
  result_t            fifo_mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_CW-1:0] count;

  // datapath
  logic [STEP_W-1:0]     step_eff;
  logic [GRAY_SUM_W-1:0] gray_sum;
  logic [GRAY_W-1:0]     gray;
  logic [RAW_W-1:0]      raw_col;
  logic [RAW_W-1:0]      raw_row;
  logic                  point_hit;
  logic                  s1_fire;
  logic                  pixel_take;
  logic                  pop;
  logic [1:0]            push_n;
  logic [FIFO_AW-1:0]    wr_ptr_plus1;
  result_t               entry0;
  result_t               entry1;
  counter_t              col_adv;
  counter_t              row_adv;

  // advance a phase/position pair by one, parking on overflow
  function automatic counter_t advance(input logic [PHASE_W-1:0] phase,
                                       input logic [POS_W-1:0]   pos,
                                       input logic [STEP_W-1:0]  step);
    counter_t r;
    r.phase = phase;
    r.pos   = pos;
    if (({1'b0, phase} + 5'd1) >= {1'b0, step}) begin
      if (pos < POS_MAX) begin
        r.pos   = pos + POS_W'(1);
        r.phase = '0;
      end else begin
        r.phase = PHASE_PARK;
      end
    end else begin
      r.phase = phase + PHASE_W'(1);
    end
    return r;
  endfunction

  // step of zero behaves as one
  assign step_eff = (decimation_step == '0) ? STEP_W'(1) : decimation_step;

  // gray = (r*38 + g*75 + b*15) >> 7
  assign gray_sum = GRAY_SUM_W'(s1_pixel[15:11]) * WEIGHT_R
                  + GRAY_SUM_W'(s1_pixel[10:5])  * WEIGHT_G
                  + GRAY_SUM_W'(s1_pixel[4:0])   * WEIGHT_B;
  assign gray     = gray_sum[GRAY_SUM_W-1:GRAY_SHIFT];

  // raw positions, only used when both phases are zero
  assign raw_col = RAW_W'(decimated_x) * RAW_W'(step_eff);
  assign raw_row = RAW_W'(decimated_y) * RAW_W'(step_eff);

  assign point_hit = (column_phase == '0) && (row_phase == '0)
                  && (int'(raw_col) < MAX_COLUMNS) && (int'(raw_row) < MAX_ROWS)
                  && (GRAY_W'(gray) > gray_threshold);

  assign col_adv = advance(column_phase, decimated_x, step_eff);
  assign row_adv = advance(row_phase, decimated_y, step_eff);

  // the input register drains once two queue slots are free
  assign s1_fire     = s1_valid && (count <= FIFO_CW'(FIFO_DEPTH - 2));
  assign pixel_stall = s1_valid && !s1_fire;
  assign pixel_take  = pixel_valid && !pixel_stall;

  assign pop = result_valid && !result_stall;

  // point first, then frame done
  always_comb begin
    entry0.kind    = point_hit ? KIND_POINT : KIND_FRAME;
    entry0.point_x = point_hit ? decimated_x : '0;
    entry0.point_y = point_hit ? decimated_y : '0;
    entry0.last    = !(point_hit && s1_frame_end);
    entry1.kind    = KIND_FRAME;
    entry1.point_x = '0;
    entry1.point_y = '0;
    entry1.last    = 1'b1;
    push_n = 2'(point_hit) + 2'(s1_frame_end);
    if (!s1_fire) begin
      push_n = 2'd0;
    end
  end

  assign wr_ptr_plus1 = wr_ptr + FIFO_AW'(1);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      gray_threshold  <= THRESHOLD_RESET;
      decimation_step <= STEP_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_GRAY_THRESHOLD:  gray_threshold  <= cfg_data[THRESHOLD_W-1:0];
        REG_DECIMATION_STEP: decimation_step <= cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pixel_take) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pixel_take) begin
      s1_pixel     <= pixel;
      s1_row_end   <= row_end;
      s1_frame_end <= frame_end;
    end
  end

  // counters move when the pixel leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      column_phase <= '0;
      decimated_x  <= '0;
      row_phase    <= '0;
      decimated_y  <= '0;
    end else if (s1_fire) begin
      priority if (s1_frame_end) begin
        column_phase <= '0;
        decimated_x  <= '0;
        row_phase    <= '0;
        decimated_y  <= '0;
      end else if (s1_row_end) begin
        column_phase <= '0;
        decimated_x  <= '0;
        row_phase    <= row_adv.phase;
        decimated_y  <= row_adv.pos;
      end else begin
        column_phase <= col_adv.phase;
        decimated_x  <= col_adv.pos;
      end
    end
  end

  // result queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_AW'(push_n);
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      count <= count + FIFO_CW'(push_n) - FIFO_CW'(pop);
    end
  end

  // result queue storage
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      fifo_mem[wr_ptr] <= entry0;
    end
    if (push_n == 2'd2) begin
      fifo_mem[wr_ptr_plus1] <= entry1;
    end
  end

  assign result_valid = (count != '0);
  assign kind         = fifo_mem[rd_ptr].kind;
  assign point_x      = fifo_mem[rd_ptr].point_x;
  assign point_y      = fifo_mem[rd_ptr].point_y;
  assign last         = fifo_mem[rd_ptr].last;

  // queue never overfills
  a_fifo_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FIFO_CW'(FIFO_DEPTH))
    else $error("result queue over depth");

  // stall only while the input register holds a pixel
  a_stall_held: assert property (@(posedge clk) disable iff (rst)
    pixel_stall |-> s1_valid)
    else $error("pixel stall without a held pixel");

  // frame end clears all counters
  a_frame_clear: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && s1_frame_end) |=>
      (column_phase == '0) && (decimated_x == '0)
      && (row_phase == '0) && (decimated_y == '0))
    else $error("counters not cleared at frame end");

  // an empty queue with a waiting pixel always drains it
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && (count == '0)) |-> s1_fire)
    else $error("input register stuck with empty queue");

endmodule

`default_nettype wire

### tb/rgb565_decimate_binarize_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb565_decimate_binarize_checker
// watches the register port and both stream channels, tracks the decimation
// counters and settings of the block, predicts marked points and frame ends
// for every pixel transfer and compares each result transfer in order
// ----------------------------------------------------------------------------

module rgb565_decimate_binarize_checker (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                cfg_write,
  input  wire  [rgbdb_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire  [rgbdb_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire                                pixel_valid,
  input  wire                                pixel_stall,
  input  wire  [rgbdb_pkg::PIXEL_W-1:0]      pixel,
  input  wire                                row_end,
  input  wire                                frame_end,
  input  wire                                result_valid,
  input  wire                                result_stall,
  input  wire                                kind,
  input  wire  [rgbdb_pkg::POS_W-1:0]        point_x,
  input  wire  [rgbdb_pkg::POS_W-1:0]        point_y,
  input  wire                                last,
  output int                                 fail_count,
  output int                                 outstanding,
  output int                                 results_checked,
  output int                                 frames_checked
);

  import rgbdb_pkg::*;

  logic [THRESHOLD_W-1:0] threshold_q;
  logic [STEP_W-1:0]      step_q;
  logic [PHASE_W-1:0]     col_phase;
  logic [POS_W-1:0]       dec_x;
  logic [PHASE_W-1:0]     row_phase;
  logic [POS_W-1:0]       dec_y;

  result_t outputs_due[$];
  int      mismatches = 0;
  int      seen_total = 0;
  int      seen_frames = 0;

  // one phase/position pair steps forward, parking at the far edge
  task automatic advance_counter(inout logic [PHASE_W-1:0] phase,
                                 inout logic [POS_W-1:0] pos, input int stride);
    if (int'(phase) + 1 >= stride) begin
      if (pos < POS_MAX) begin
        pos   = pos + 1'b1;
        phase = '0;
      end else begin
        phase = PHASE_PARK;
      end
    end else begin
      phase = phase + 1'b1;
    end
  endtask

  task automatic binarize_pixel(input logic [PIXEL_W-1:0] px, input logic ends_row,
                                input logic ends_frame);
    int      gray;
    int      stride;
    int      raw_col;
    int      raw_row;
    result_t made[$];
    result_t one;
    gray = (int'(px[15:11]) * int'(WEIGHT_R) + int'(px[10:5]) * int'(WEIGHT_G) +
            int'(px[4:0]) * int'(WEIGHT_B)) >> GRAY_SHIFT;
    stride  = (step_q == '0) ? 1 : int'(step_q);
    raw_col = int'(dec_x) * stride + int'(col_phase);
    raw_row = int'(dec_y) * stride + int'(row_phase);
    if (col_phase == '0 && row_phase == '0 && raw_col < MAX_COLUMNS &&
        raw_row < MAX_ROWS && gray > int'(threshold_q)) begin
      one = '{kind: KIND_POINT, point_x: dec_x, point_y: dec_y, last: 1'b0};
      made.push_back(one);
    end
    if (ends_frame) begin
      one = '{kind: KIND_FRAME, point_x: '0, point_y: '0, last: 1'b0};
      made.push_back(one);
      col_phase = '0;
      dec_x     = '0;
      row_phase = '0;
      dec_y     = '0;
    end else if (ends_row) begin
      col_phase = '0;
      dec_x     = '0;
      advance_counter(row_phase, dec_y, stride);
    end else begin
      advance_counter(col_phase, dec_x, stride);
    end
    if (made.size() != 0) begin
      made[made.size() - 1].last = 1'b1;
    end
    foreach (made[i]) begin
      outputs_due.push_back(made[i]);
    end
  endtask

  task automatic compare_result();
    result_t seen;
    result_t want;
    seen = '{kind: kind, point_x: point_x, point_y: point_y, last: last};
    seen_total++;
    if (kind == KIND_FRAME) begin
      seen_frames++;
    end
    if (outputs_due.size() == 0) begin
      $display("%0t: result with none expected, actual kind=%0d x=%0d y=%0d last=%0d",
               $time, seen.kind, seen.point_x, seen.point_y, seen.last);
      mismatches++;
    end else begin
      want = outputs_due.pop_front();
      if (seen !== want) begin
        $display({"%0t: result mismatch, expected kind=%0d x=%0d y=%0d last=%0d,",
                  " actual kind=%0d x=%0d y=%0d last=%0d"},
                 $time, want.kind, want.point_x, want.point_y, want.last,
                 seen.kind, seen.point_x, seen.point_y, seen.last);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      threshold_q = THRESHOLD_RESET;
      step_q      = STEP_RESET;
      col_phase   = '0;
      dec_x       = '0;
      row_phase   = '0;
      dec_y       = '0;
      outputs_due.delete();
    end else begin
      if (cfg_write) begin
        if (cfg_index == REG_GRAY_THRESHOLD) begin
          threshold_q = cfg_data[THRESHOLD_W-1:0];
        end else begin
          step_q = cfg_data[STEP_W-1:0];
        end
      end
      if (pixel_valid && !pixel_stall) begin
        binarize_pixel(pixel, row_end, frame_end);
      end
      if (result_valid && !result_stall) begin
        compare_result();
      end
    end
    fail_count      <= mismatches;
    outstanding     <= outputs_due.size();
    results_checked <= seen_total;
    frames_checked  <= seen_frames;
  end

endmodule

### tb/rgb565_decimate_binarize_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb565_decimate_binarize_top_tb
// feeds pixel frames to the decimate/binarize block under many threshold and
// step settings, with random gaps and stalls on both streams; the checker
// beside the block predicts every point and frame end and counts mismatches
// ----------------------------------------------------------------------------

module rgb565_decimate_binarize_top_tb;
  import rgbdb_pkg::*;

  localparam int RANDOM_ITEMS   = 760;   // pixels in the random part
  localparam int SETTLE_CYCLES  = 8;     // covers a pixel still in flight
  localparam int LONG_HOLD      = 300;   // receiver hold-off in the burst
  localparam int BURST_PIXELS   = 48;
  localparam int ROW_REACH      = 70;    // row that the widest step puts off frame
  localparam int WATCHDOG_LIMIT = 2000;  // cycles without any transfer

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_GRAY_THRESHOLD;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   pixel_valid = 1'b0;
  logic                   pixel_stall;
  logic [PIXEL_W-1:0]     pixel = '0;
  logic                   row_end = 1'b0;
  logic                   frame_end = 1'b0;
  logic                   result_valid;
  logic                   result_stall = 1'b0;
  logic                   kind;
  logic [POS_W-1:0]       point_x;
  logic [POS_W-1:0]       point_y;
  logic                   last;

  int fail_count;
  int outstanding;
  int results_checked;
  int frames_checked;

  int pixels_sent   = 0;
  int settings_run  = 0;
  int hold_requests = 0;
  int holds_done    = 0;
  int idle_cycles   = 0;
  bit quiet         = 1'b0;  // no random gaps and no random stalls while set

  rgb565_decimate_binarize_top DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .pixel        (pixel),
    .row_end      (row_end),
    .frame_end    (frame_end),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .kind         (kind),
    .point_x      (point_x),
    .point_y      (point_y),
    .last         (last)
  );

  rgb565_decimate_binarize_checker result_check (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .pixel_valid     (pixel_valid),
    .pixel_stall     (pixel_stall),
    .pixel           (pixel),
    .row_end         (row_end),
    .frame_end       (frame_end),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .kind            (kind),
    .point_x         (point_x),
    .point_y         (point_y),
    .last            (last),
    .fail_count      (fail_count),
    .outstanding     (outstanding),
    .results_checked (results_checked),
    .frames_checked  (frames_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog: any transfer on either stream restarts the count
  always @(posedge clk) begin
    if (rst || (pixel_valid && !pixel_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("rgb565_decimate_binarize_top test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: random stall before each transfer, one long hold on request
  initial begin : result_sink
    int wait_cycles;
    forever begin
      if (holds_done != hold_requests) begin
        // long hold so the result queue fills and the pixel side backs up
        result_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        holds_done++;
      end
      wait_cycles = quiet ? 0 : $urandom_range(0, 7);
      if (wait_cycles != 0) begin
        result_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      result_stall <= 1'b0;
      do @(posedge clk); while (!(result_valid && !result_stall));
    end
  end

  function automatic logic [PIXEL_W-1:0] random_pixel();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return PIXEL_W'($urandom);
    endcase
  endfunction

  // one pixel transfer; valid stays high afterwards unless the next gap drops it
  task automatic send_pixel(input logic [PIXEL_W-1:0] px, input logic ends_row,
                            input logic ends_frame);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      pixel_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pixel_valid <= 1'b1;
    pixel       <= px;
    row_end     <= ends_row;
    frame_end   <= ends_frame;
    do @(posedge clk); while (pixel_stall);
    pixels_sent++;
  endtask

  // stop offering pixels and wait out every awaited result
  task automatic drain_results();
    pixel_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // both registers are written only once the block has gone idle
  task automatic configure(input logic [CFG_DATA_W-1:0] thr_data,
                           input logic [CFG_DATA_W-1:0] step_data);
    drain_results();
    cfg_write <= 1'b1;
    cfg_index <= REG_GRAY_THRESHOLD;
    cfg_data  <= thr_data;
    @(posedge clk);
    cfg_index <= REG_DECIMATION_STEP;
    cfg_data  <= step_data;
    @(posedge clk);
    cfg_write <= 1'b0;
    settings_run++;
  endtask

  // a frame of random pixels with stray row ends, frame ends without a row
  // end and early frame ends mixed in; an open frame carries into the next
  // setting so the step changes mid-frame
  task automatic send_frame(input int width, input int height, input bit ends_it);
    logic row_last;
    logic frame_last;
    for (int r = 0; r < height; r++) begin
      for (int c = 0; c < width; c++) begin
        row_last   = (c == width - 1) || ($urandom_range(0, 39) == 0);
        frame_last = ends_it && (((r == height - 1) && (c == width - 1)) ||
                                 ($urandom_range(0, 149) == 0));
        if (frame_last && $urandom_range(0, 5) == 0) begin
          row_last = 1'b0;
        end
        send_pixel(random_pixel(), row_last, frame_last);
        if (frame_last) begin
          return;
        end
      end
    end
  endtask

  initial begin : stimulus
    int                     stream_start;
    int                     stride;
    int                     w_cap;
    int                     h_cap;
    int                     n_frames;
    logic [THRESHOLD_W-1:0] thr;
    logic [STEP_W-1:0]      stp;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset settings: threshold 35, one kept pixel in five
    send_pixel(16'hFFFF, 1'b0, 1'b0);          // brightest pixel at the origin
    repeat (4) send_pixel(16'h07E0, 1'b0, 1'b0);  // columns off phase
    send_pixel(16'h07E0, 1'b1, 1'b0);          // pure green kept at x=1, ends row
    send_pixel(16'hF800, 1'b1, 1'b1);          // row off phase, frame end only

    configure(6'd36, 6'd1);
    send_pixel(16'h07E0, 1'b0, 1'b0);          // gray equal to threshold: no mark
    send_pixel(16'h001F, 1'b0, 1'b0);          // pure blue
    send_pixel(16'hFFFF, 1'b1, 1'b1);          // point then frame end, one pixel

    configure(6'd0, 6'd0);                     // step of zero keeps every pixel
    send_pixel(16'h0000, 1'b0, 1'b0);
    send_pixel(16'h0040, 1'b0, 1'b0);          // gray one, just above zero
    send_pixel(16'h0020, 1'b1, 1'b0);
    send_pixel(16'h0800, 1'b0, 1'b1);          // frame end without row end

    configure(6'd63, 6'd15);                   // threshold out of gray range
    send_pixel(16'hFFFF, 1'b1, 1'b1);

    // burst of marked pixels against a long receiver hold
    configure(6'd0, 6'd1);
    quiet = 1'b1;
    hold_requests++;
    for (int i = 0; i < BURST_PIXELS; i++) begin
      send_pixel(random_pixel() | 16'hF800, i == BURST_PIXELS - 1, i == BURST_PIXELS - 1);
    end
    quiet = 1'b0;

    // saturation frame: column position runs to the edge and parks, a wider
    // step puts the raw column beyond the frame, then the rows climb far
    // enough that the widest step puts the raw row beyond the frame
    configure(6'd0, 6'd1);
    repeat (MAX_COLUMNS - 1) send_pixel(16'hFFFF, 1'b0, 1'b0);
    configure(6'd0, 6'd2);
    repeat (3) send_pixel(16'hFFFF, 1'b0, 1'b0);
    configure(6'd0, 6'd1);
    send_pixel(16'hFFFF, 1'b1, 1'b0);          // parked column, no mark
    repeat (ROW_REACH - 1) send_pixel(random_pixel(), 1'b1, 1'b0);
    send_pixel(16'hFFFF, 1'b0, 1'b0);          // still inside the frame at step one
    configure(6'd0, 6'd15);
    send_pixel(16'hFFFF, 1'b0, 1'b0);          // raw row beyond the frame
    send_pixel(16'hFFFF, 1'b1, 1'b0);
    send_pixel(16'hFFFF, 1'b1, 1'b1);

    // random settings, each with a few frames of random size
    stream_start = pixels_sent;
    while (pixels_sent - stream_start < RANDOM_ITEMS) begin
      case ($urandom_range(0, 5))
        0:       thr = '0;
        1:       thr = '1;
        2:       thr = THRESHOLD_W'($urandom_range(0, 63));
        default: thr = THRESHOLD_W'($urandom_range(10, 45));
      endcase
      case ($urandom_range(0, 5))
        0:       stp = '0;
        1:       stp = 4'd1;
        2:       stp = '1;
        default: stp = STEP_W'($urandom_range(0, 15));
      endcase
      // upper data bits are ignored by the step register
      configure(thr, {2'($urandom), stp});
      quiet    = ($urandom_range(0, 3) == 0);
      stride   = (stp == '0) ? 1 : int'(stp);
      w_cap    = (3 * stride + 2 > 24) ? 24 : 3 * stride + 2;
      h_cap    = (2 * stride + 2 > 18) ? 18 : 2 * stride + 2;
      n_frames = $urandom_range(1, 3);
      for (int f = 0; f < n_frames; f++) begin
        send_frame($urandom_range(1, w_cap), $urandom_range(1, h_cap),
                   !((f == n_frames - 1) && ($urandom_range(0, 3) == 0)));
      end
    end
    quiet = 1'b0;

    drain_results();
    $display("covered %0d pixel transfers over %0d register settings,",
             pixels_sent, settings_run);
    $display("a parked column, rows beyond the frame and %0d results (%0d frame ends)",
             results_checked, frames_checked);
    if (fail_count == 0 && outstanding == 0) begin
      $display("rgb565_decimate_binarize_top test passed");
    end else begin
      $display("rgb565_decimate_binarize_top test failed");
    end
    $finish;
  end

endmodule
